@@ sv/lzwc_pkg.sv @@
// Shared types and constants for the LZ window copy decoder.
package lzwc_pkg;

    // Field widths of the stream payloads
    localparam int CMD_W     = 2;
    localparam int LIT_W     = 8;
    localparam int POS_W     = 17;
    localparam int LEN_W     = 10;
    localparam int S_TDATA_W = 40;   // literal + position + length, padded to bytes
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // Token commands on the input stream
    localparam logic [CMD_W-1:0] CMD_LITERAL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MATCH    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // Work kinds handed from front to back
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LIT  = 2'd0;
    localparam t_kind KIND_COPY = 2'd1;
    localparam t_kind KIND_END  = 2'd2;
    localparam t_kind KIND_ERR  = 2'd3;

    // Bit positions in the result tuser
    localparam int TUSER_ERR_BIT = 0;
    localparam int TUSER_END_BIT = 1;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    typedef struct packed {
        t_kind              kind;
        logic [LIT_W-1:0]   lit;
        logic [POS_W-1:0]   pos;
        logic [LEN_W-1:0]   len;
    } t_token;

endpackage

@@ sv/lzwc_front.sv @@
// Front end: accepts tokens, classifies them and pushes work into the queue.
module lzwc_front
    import lzwc_pkg::*;
#(
    parameter int MIN_MATCH_LENGTH = 4,
    parameter int MAX_MATCH_LENGTH = 64
) (
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic                 i_full,
    input  logic                 i_clearing,
    output logic                 o_push,
    output t_token               o_tok
);

    logic [LEN_W-1:0] len;
    logic             accept;

    assign len        = i_s_tdata[LIT_W+POS_W +: LEN_W];
    assign o_s_tready = !i_full && !i_clearing;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_tok.lit  = i_s_tdata[0 +: LIT_W];
        o_tok.pos  = i_s_tdata[LIT_W +: POS_W];
        o_tok.len  = len;
        o_tok.kind = KIND_LIT;
        o_push     = accept;
        case (i_s_tuser)
            CMD_LITERAL: o_tok.kind = KIND_LIT;
            CMD_END:     o_tok.kind = KIND_END;
            CMD_MATCH: begin
                if (len inside {[MIN_MATCH_LENGTH:MAX_MATCH_LENGTH]}) begin
                    o_tok.kind = KIND_COPY;
                end else begin
                    o_tok.kind = KIND_ERR;
                end
            end
            default: o_push = 1'b0;   // reserved command is consumed and dropped
        endcase
    end

endmodule

@@ sv/lzwc_queue.sv @@
// Two-entry token queue between front end and back end.
module lzwc_queue
    import lzwc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_tok,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_token o_tok
);

    t_token               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count,  n_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

@@ sv/lzwc_back.sv @@
// Back end: window memory, copy buffer, copy sequencer and result register.
module lzwc_back
    import lzwc_pkg::*;
#(
    parameter int POSITION_BITS    = 17,
    parameter int MAX_MATCH_LENGTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_token               i_q_tok,
    output logic                 o_q_pop,
    output logic                 o_clearing,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tlast,
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    localparam int LEN_BITS = $clog2(MAX_MATCH_LENGTH + 1);
    localparam int CB_AW    = $clog2(MAX_MATCH_LENGTH);
    localparam int WIN_SIZE = 2 ** POSITION_BITS;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_READ    = 3'd2;
    localparam logic [2:0] ST_WR_RD   = 3'd3;
    localparam logic [2:0] ST_WR_EMIT = 3'd4;

    logic [2:0]               r_state,    n_state;
    logic [POSITION_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [POSITION_BITS-1:0] r_wp,       n_wp;
    logic [POSITION_BITS-1:0] r_src,      n_src;
    logic [LEN_BITS-1:0]      r_len,      n_len;
    logic [LEN_BITS-1:0]      r_ridx,     n_ridx;
    logic [LEN_BITS-1:0]      r_widx,     n_widx;
    logic                     r_cap_vld,  n_cap_vld;
    logic [CB_AW-1:0]         r_cap_idx,  n_cap_idx;

    logic                     r_out_vld,  n_out_vld;
    logic [LIT_W-1:0]         r_out_byte, n_out_byte;
    logic                     r_out_last, n_out_last;
    logic                     r_out_err,  n_out_err;
    logic                     r_out_end,  n_out_end;

    logic [7:0]               r_win [WIN_SIZE];
    logic [7:0]               r_win_q;
    logic                     win_we;
    logic [POSITION_BITS-1:0] win_waddr;
    logic [7:0]               win_wdata;

    logic [7:0]               r_cbuf [MAX_MATCH_LENGTH];
    logic [7:0]               r_cb_q;

    logic                     out_free;
    logic                     emit_last;

    assign out_free   = !r_out_vld || i_m_tready;
    assign emit_last  = (LEN_BITS'(r_widx + 1'b1) == r_len);
    assign o_clearing = (r_state == ST_CLEAR);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_wp       = r_wp;
        n_src      = r_src;
        n_len      = r_len;
        n_ridx     = r_ridx;
        n_widx     = r_widx;
        n_cap_vld  = 1'b0;
        n_cap_idx  = r_ridx[CB_AW-1:0];
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        n_out_err  = r_out_err;
        n_out_end  = r_out_end;
        win_we     = 1'b0;
        win_waddr  = r_wp;
        win_wdata  = r_cb_q;
        o_q_pop    = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                win_we     = 1'b1;
                win_waddr  = r_clr_addr;
                win_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_tok.kind)
                        KIND_COPY: begin
                            o_q_pop = 1'b1;
                            n_src   = POSITION_BITS'(i_q_tok.pos);
                            n_len   = LEN_BITS'(i_q_tok.len);
                            n_ridx  = '0;
                            n_state = ST_READ;
                        end
                        KIND_LIT: begin
                            if (out_free) begin
                                o_q_pop    = 1'b1;
                                win_we     = 1'b1;
                                win_wdata  = i_q_tok.lit;
                                n_wp       = r_wp + 1'b1;
                                n_out_vld  = 1'b1;
                                n_out_byte = i_q_tok.lit;
                                n_out_last = 1'b1;
                                n_out_err  = 1'b0;
                                n_out_end  = 1'b0;
                            end
                        end
                        default: begin
                            // end marker or bad length: one zero-byte result
                            if (out_free) begin
                                o_q_pop    = 1'b1;
                                n_out_vld  = 1'b1;
                                n_out_byte = '0;
                                n_out_last = 1'b1;
                                n_out_err  = (i_q_tok.kind == KIND_ERR);
                                n_out_end  = (i_q_tok.kind == KIND_END);
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                // one window read issued per cycle; its registered read data is then written into the buffer
                if (r_ridx != r_len) begin
                    n_src     = r_src + 1'b1;
                    n_ridx    = r_ridx + 1'b1;
                    n_cap_vld = 1'b1;
                end else begin
                    n_widx  = '0;
                    n_state = ST_WR_RD;
                end
            end
            ST_WR_RD: begin
                n_state = ST_WR_EMIT;
            end
            ST_WR_EMIT: begin
                if (out_free) begin
                    win_we     = 1'b1;
                    n_wp       = r_wp + 1'b1;
                    n_widx     = r_widx + 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_byte = r_cb_q;
                    n_out_last = emit_last;
                    n_out_err  = 1'b0;
                    n_out_end  = 1'b0;
                    n_state    = emit_last ? ST_IDLE : ST_WR_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_ridx     <= '0;
            r_widx     <= '0;
            r_cap_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_wp       <= n_wp;
            r_ridx     <= n_ridx;
            r_widx     <= n_widx;
            r_cap_vld  <= n_cap_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_len      <= n_len;
        r_cap_idx  <= n_cap_idx;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
        r_out_end  <= n_out_end;
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win[win_waddr] <= win_wdata;
        end
        r_win_q <= r_win[r_src];
    end

    // copy buffer: filled from the window read data, read back during emission
    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            r_cbuf[r_cap_idx] <= r_win_q;
        end
        r_cb_q <= r_cbuf[r_widx[CB_AW-1:0]];
    end

    assign o_m_tvalid                = r_out_vld;
    assign o_m_tdata                 = r_out_byte;
    assign o_m_tlast                 = r_out_last;
    assign o_m_tuser[TUSER_ERR_BIT]  = r_out_err;
    assign o_m_tuser[TUSER_END_BIT]  = r_out_end;

endmodule

@@ sv/lz_window_copy_decoder_unit.sv @@
// Top level of the LZ window copy decoder: front end, token queue and back end.
//
//  channel  dir  handshake                tdata                         tuser / tlast
//  s_*      in   i_s_tvalid / o_s_tready  [7:0] literal, [24:8] pos,    tuser = command
//                                         [34:25] length, [39:35] zero
//  m_*      out  o_m_tvalid / i_m_tready  [7:0] out byte                tuser[0] length error,
//                                                                       tuser[1] stream end,
//                                                                       tlast = last of run
//
//  After reset all 2**POSITION_BITS window bytes are swept to zero, one byte
//  a cycle, during which o_s_tready stays low. Literal, end and bad-length
//  tokens each yield one result straight from the idle state once the
//  output register is free. A match of length L first reads its L window
//  bytes into the copy buffer, then takes a copy buffer read and an emit
//  step for each byte, since each memory has a single read port.
//  The output register holds a result under backpressure; the two-entry
//  token queue takes tokens while the back end works, until it is full.
module lz_window_copy_decoder_unit
    import lzwc_pkg::*;
#(
    parameter int POSITION_BITS    = 17,
    parameter int MAX_MATCH_LENGTH = 64,
    parameter int MIN_MATCH_LENGTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // literal_byte, match_position, match_length
    input  logic [CMD_W-1:0]     i_s_tuser,   // command
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // out_byte
    output logic                 o_m_tlast,   // last_of_run
    output logic [M_TUSER_W-1:0] o_m_tuser    // length_error, stream_end
);

    // classified token into the queue
    logic   push;
    t_token push_tok;
    logic   q_full;

    // queue head to the back end
    logic   q_valid;
    t_token q_tok;
    logic   q_pop;

    // window sweep in progress after reset
    logic   clearing;

    lzwc_front #(
        .MIN_MATCH_LENGTH (MIN_MATCH_LENGTH),
        .MAX_MATCH_LENGTH (MAX_MATCH_LENGTH)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_tok      (push_tok)
    );

    lzwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    lzwc_back #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_MATCH_LENGTH (MAX_MATCH_LENGTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_tok    (q_tok),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // no token may enter while the window sweep runs
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !(i_s_tvalid && o_s_tready))
        else $error("token transfer during window clear");

    // error and end markers are single zero-byte results closing their run
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[TUSER_ERR_BIT] || o_m_tuser[TUSER_END_BIT]))
            |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("marker result with data or without tlast");

    // a result is never both a length error and a stream end
    a_marker_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[TUSER_ERR_BIT] && o_m_tuser[TUSER_END_BIT]))
        else $error("length error and stream end flagged together");

    // the back end never pops an empty queue
    a_pop_needs_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue pop without a token");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for lz_window_copy_decoder_unit: a window replica predicts each result.
module tb;
    import lzwc_pkg::*;

    // Block configuration under test (defaults of the top level)
    localparam int WIN_BITS = 17;
    localparam int MAX_LEN  = 64;
    localparam int MIN_LEN  = 4;
    localparam int WIN_SIZE = 1 << WIN_BITS;

    // Settle at the end for longer than the longest match takes.
    localparam int DRAIN_CYCLES  = 3 * MAX_LEN + 32;
    // Post-reset window sweep keeps the input closed while it clears all WIN_SIZE bytes.
    localparam int IDLE_LIMIT    = 4 * WIN_SIZE;
    localparam int RANDOM_TOKENS = 210;

    // One output transfer: byte plus its three flags
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       len_err;
        logic       stream_end;
    } t_out_item;

    // Window replica: mirrors the window and write pointer, and holds the
    // output transfers still owed by the block, oldest first.
    class window_scoreboard;
        logic [7:0]          win [WIN_SIZE];
        logic [WIN_BITS-1:0] wr_ptr;
        t_out_item           owed [$];
        int                  mismatches;

        function new();
            foreach (win[a]) win[a] = 8'h00;
            wr_ptr     = '0;
            mismatches = 0;
        endfunction

        function t_out_item out_item(logic [7:0] data, logic last, logic err, logic fin);
            t_out_item it;
            it.data       = data;
            it.last       = last;
            it.len_err    = err;
            it.stream_end = fin;
            return it;
        endfunction

        // Accepted token: update the window and queue the bytes it yields.
        function void note_token(logic [CMD_W-1:0] cmd, logic [LIT_W-1:0] lit,
                                 logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
            logic [7:0]          copy_buf [MAX_LEN];
            logic [WIN_BITS-1:0] src;
            case (cmd)
                CMD_LITERAL: begin
                    win[wr_ptr] = lit;
                    wr_ptr      = wr_ptr + 1'b1;
                    owed.push_back(out_item(lit, 1'b1, 1'b0, 1'b0));
                end
                CMD_END: owed.push_back(out_item(8'h00, 1'b1, 1'b0, 1'b1));
                CMD_MATCH: begin
                    if (len < MIN_LEN || len > MAX_LEN) begin
                        owed.push_back(out_item(8'h00, 1'b1, 1'b1, 1'b0));
                    end else begin
                        // gather all sources first: overlap sees old contents
                        src = pos[WIN_BITS-1:0];
                        for (int i = 0; i < len; i++) begin
                            copy_buf[i] = win[src];
                            src         = src + 1'b1;
                        end
                        for (int i = 0; i < len; i++) begin
                            win[wr_ptr] = copy_buf[i];
                            wr_ptr      = wr_ptr + 1'b1;
                            owed.push_back(out_item(copy_buf[i], i + 1 == len, 1'b0, 1'b0));
                        end
                    end
                end
                default: ;  // reserved command: dropped by the block
            endcase
        endfunction

        function void check_output(logic [7:0] data, logic last, logic err, logic fin);
            t_out_item want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: byte %02h last %0b err %0b end %0b",
                             data, last, err, fin);
                return;
            end
            want = owed.pop_front();
            if (data !== want.data || last !== want.last ||
                err !== want.len_err || fin !== want.stream_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp byte %02h last %0b err %0b end %0b, ",
                              "got byte %02h last %0b err %0b end %0b"},
                             want.data, want.last, want.len_err, want.stream_end,
                             data, last, err, fin);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // DUT signals; every input known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;       // literal, position, length, zero pad
    logic [CMD_W-1:0]     i_s_tuser  = CMD_LITERAL; // command
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;             // out byte
    logic                 o_m_tlast;             // last of run
    logic [M_TUSER_W-1:0] o_m_tuser;             // length error, stream end

    window_scoreboard sb;
    int burst_left  = 0;
    int idle_cycles = 0;

    // Sink-side stall pattern state
    int sink_mode  = 0;
    int mode_left  = 0;
    int stall_left = 0;

    lz_window_copy_decoder_unit #(
        .POSITION_BITS   (WIN_BITS),
        .MAX_MATCH_LENGTH(MAX_LEN),
        .MIN_MATCH_LENGTH(MIN_LEN)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

    // 8-unit clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sink stalls: modes of full speed, coin flip, sparse ready and long stalls,
    // each held for a random stretch so stalls land on every phase of a copy.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
        end else begin
            mode_left--;
        end
        case (sink_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(0, 20);
                    i_m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Output check and watchdog; both sample at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_output(o_m_tdata, o_m_tlast,
                                o_m_tuser[TUSER_ERR_BIT], o_m_tuser[TUSER_END_BIT]);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Source pacing: bursts of back-to-back tokens, random gaps in between
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // One token transfer; called at a falling edge, returns at a falling edge
    task automatic send_token(logic [CMD_W-1:0] cmd, logic [LIT_W-1:0] lit,
                              logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{(S_TDATA_W - LIT_W - POS_W - LEN_W){1'b0}}, len, pos, lit};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_token(cmd, lit, pos, len);
        @(negedge i_clk);
        pace();
    endtask

    // Random token: mostly literals and back references into recent output,
    // plus bad lengths, end tokens and the reserved command as noise.
    task automatic random_token(output logic [CMD_W-1:0] cmd, output logic [LIT_W-1:0] lit,
                                output logic [POS_W-1:0] pos, output logic [LEN_W-1:0] len);
        int r;
        r   = $urandom_range(0, 99);
        lit = LIT_W'($urandom);
        pos = POS_W'($urandom);
        len = LEN_W'($urandom);
        if (r < 38) begin
            cmd = CMD_LITERAL;
        end else if (r < 85) begin
            cmd = CMD_MATCH;
            r   = $urandom_range(0, 99);
            if (r < 8)
                len = LEN_W'($urandom_range(0, MIN_LEN - 1));
            else if (r < 16)
                len = LEN_W'($urandom_range(MAX_LEN + 1, 1023));
            else if (r < 40)
                len = LEN_W'($urandom_range(MIN_LEN, MAX_LEN));
            else
                len = LEN_W'($urandom_range(MIN_LEN, 16));
            // near references give overlap and real content; the rest lands anywhere
            if ($urandom_range(0, 3) != 0)
                pos = POS_W'(sb.wr_ptr - WIN_BITS'($urandom_range(1, 400)));
        end else if (r < 93) begin
            cmd = CMD_END;
        end else begin
            cmd = CMD_RESERVED;
        end
    endtask

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [LIT_W-1:0] lit;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        int               counted;

        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, then matches against known content
        send_token(CMD_LITERAL, 8'h00, '1, '1);
        send_token(CMD_LITERAL, 8'hFF, '0, '0);
        send_token(CMD_LITERAL, 8'hA5, '1, '1);
        send_token(CMD_LITERAL, 8'h5A, '0, '0);
        send_token(CMD_LITERAL, 8'h3C, '1, '1);
        send_token(CMD_LITERAL, 8'hC3, '0, '0);
        send_token(CMD_MATCH, 8'hFF, 17'd0, LEN_W'(MIN_LEN));
        // source runs into the destination: old contents come back
        send_token(CMD_MATCH, 8'h00, sb.wr_ptr - 17'd2, 10'd6);
        send_token(CMD_MATCH, 8'h00, sb.wr_ptr, 10'd5);
        send_token(CMD_MATCH, 8'hFF, 17'd0, LEN_W'(MAX_LEN));
        send_token(CMD_MATCH, 8'h00, sb.wr_ptr - 17'd1, 10'd12);
        // source wraps past the top of the window
        send_token(CMD_MATCH, 8'h00, POS_W'(WIN_SIZE - 3), 10'd8);
        send_token(CMD_MATCH, 8'hFF, '1, LEN_W'(MIN_LEN));
        // bad lengths on both sides, extremes included
        send_token(CMD_MATCH, 8'h00, 17'd0, LEN_W'(MIN_LEN - 1));
        send_token(CMD_MATCH, 8'hFF, '1, 10'd0);
        send_token(CMD_MATCH, 8'h00, 17'd1, LEN_W'(MAX_LEN + 1));
        send_token(CMD_MATCH, 8'hFF, 17'd2, '1);
        send_token(CMD_END, 8'hFF, '1, '1);
        send_token(CMD_RESERVED, 8'hFF, '1, '1);
        send_token(CMD_RESERVED, 8'h00, '0, '0);
        // decoding carries on after an end token
        send_token(CMD_LITERAL, 8'h81, '1, '0);
        send_token(CMD_MATCH, 8'h7E, sb.wr_ptr - 17'd1, LEN_W'(MIN_LEN));
        send_token(CMD_END, 8'h00, '0, '0);

        counted = 0;
        while (counted < RANDOM_TOKENS) begin
            random_token(cmd, lit, pos, len);
            send_token(cmd, lit, pos, len);
            if (cmd != CMD_RESERVED)
                counted++;
        end
        i_s_tvalid <= 1'b0;

        // watchdog covers a block that never delivers
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
